/* hdl/bda_pkg.sv */
// Shared types and constants for the binary to decimal ASCII converter.
package bda_pkg;

    localparam int VALUE_W    = 32;
    localparam int BCD_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int IDX_W      = 4;
    localparam int CHAR_W     = 6;
    localparam int ITER_W     = 5;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = Q_PTR_W + 1;

    localparam logic [ITER_W-1:0] ITER_LAST  = ITER_W'(VALUE_W - 1);
    localparam logic [IDX_W-1:0]  IDX_MAX    = IDX_W'(BCD_DIGITS - 1);
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef logic [BCD_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

    typedef struct packed {
        bcd_t             bcd;
        logic [IDX_W-1:0] top_idx;
    } bcd_entry_t;

    typedef struct packed {
        logic       push;
        bcd_entry_t entry;
    } q_wr_t;

    typedef struct packed {
        logic       empty;
        bcd_entry_t entry;
    } q_rd_t;

endpackage

/* hdl/bda_front.sv */
// Front end: accepts a value and runs the shift-add-3 conversion one bit per cycle.
module bda_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bda_pkg::VALUE_W-1:0]   value,
    input  logic                          q_full,
    output bda_pkg::q_wr_t                q_wr
);

    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_PUSH} state_t;

    state_t                        state_reg, state_next;
    logic [bda_pkg::VALUE_W-1:0]   val_reg, val_next;
    bda_pkg::bcd_t                 bcd_reg, bcd_next;
    logic [bda_pkg::ITER_W-1:0]    iter_reg, iter_next;
    bda_pkg::bcd_t                 bcd_adj;
    logic [bda_pkg::BCD_DIGITS*bda_pkg::DIGIT_W-1:0] adj_flat;
    logic [bda_pkg::IDX_W-1:0]     top_idx;
    logic                          in_xfer;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign adj_flat = bcd_adj;

    always_comb
    begin
        for (int i = 0; i < bda_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[i] >= 4'd5)
                bcd_adj[i] = bcd_reg[i] + 4'd3;
            else
                bcd_adj[i] = bcd_reg[i];
        end
    end

    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < bda_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[i] != '0)
                top_idx = bda_pkg::IDX_W'(i);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        bcd_next   = bcd_reg;
        iter_next  = iter_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    val_next   = value;
                    bcd_next   = '0;
                    iter_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next  = {adj_flat[bda_pkg::BCD_DIGITS*bda_pkg::DIGIT_W-2:0],
                             val_reg[bda_pkg::VALUE_W-1]};
                val_next  = {val_reg[bda_pkg::VALUE_W-2:0], 1'b0};
                iter_next = iter_reg + bda_pkg::ITER_W'(1);
                if (iter_reg == bda_pkg::ITER_LAST)
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!q_full)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        bcd_reg  <= bcd_next;
        iter_reg <= iter_next;
    end

    assign q_wr.push          = (state_reg == ST_PUSH) && !q_full;
    assign q_wr.entry.bcd     = bcd_reg;
    assign q_wr.entry.top_idx = top_idx;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == ST_CONV)
        else $error("accepted value did not start conversion");

    a_conv_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && iter_reg == bda_pkg::ITER_LAST) |=> state_reg == ST_PUSH)
        else $error("conversion did not end after last bit");

    a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.push |-> q_wr.entry.top_idx <= bda_pkg::IDX_MAX)
        else $error("top digit index out of range");

endmodule

/* hdl/bda_queue.sv */
// Two-entry queue of converted BCD words between front and back.
module bda_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  bda_pkg::q_wr_t q_wr,
    output logic           q_full,
    input  logic           pop,
    output bda_pkg::q_rd_t q_rd
);

    bda_pkg::bcd_entry_t              mem [bda_pkg::Q_DEPTH];
    logic [bda_pkg::Q_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [bda_pkg::Q_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [bda_pkg::Q_CNT_W-1:0]      count_reg, count_next;

    assign q_full     = (count_reg == bda_pkg::Q_CNT_W'(bda_pkg::Q_DEPTH));
    assign q_rd.empty = (count_reg == '0);
    assign q_rd.entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = q_wr.push ? wr_ptr_reg + bda_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + bda_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (q_wr.push && !pop)
            count_next = count_reg + bda_pkg::Q_CNT_W'(1);
        else if (pop && !q_wr.push)
            count_next = count_reg - bda_pkg::Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
            mem[wr_ptr_reg] <= q_wr.entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_wr.push && q_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_rd.empty)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (q_wr.push && !pop) |=> count_reg == $past(count_reg) + bda_pkg::Q_CNT_W'(1))
        else $error("queue count did not advance on push");

endmodule

/* hdl/bda_back.sv */
// Back end: walks a BCD word from the top nonzero digit down and emits ASCII digits.
module bda_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bda_pkg::q_rd_t               q_rd,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bda_pkg::CHAR_W-1:0]   digit_char,
    output logic                         last
);

    typedef enum logic {ST_IDLE, ST_EMIT} state_t;

    state_t                         state_reg, state_next;
    bda_pkg::bcd_t                  bcd_reg, bcd_next;
    logic [bda_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic                           out_valid_reg, out_valid_next;
    logic [bda_pkg::CHAR_W-1:0]     digit_char_reg, digit_char_next;
    logic                           last_reg, last_next;
    logic                           can_load;

    assign can_load = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == ST_IDLE) && !q_rd.empty;

    always_comb
    begin
        state_next      = state_reg;
        bcd_next        = bcd_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && out_stall;
        digit_char_next = digit_char_reg;
        last_next       = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_rd.empty)
                begin
                    bcd_next   = q_rd.entry.bcd;
                    idx_next   = q_rd.entry.top_idx;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    digit_char_next = bda_pkg::ASCII_ZERO
                                      + {2'b00, bcd_reg[idx_reg]};
                    last_next       = (idx_reg == '0);
                    idx_next        = idx_reg - bda_pkg::IDX_W'(1);
                    if (idx_reg == '0)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg        <= bcd_next;
        idx_reg        <= idx_next;
        digit_char_reg <= digit_char_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign last       = last_reg;

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (digit_char_reg >= 6'd48 && digit_char_reg <= 6'd57))
        else $error("emitted character is not a decimal digit");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && can_load && idx_reg == '0) |=> state_reg == ST_IDLE)
        else $error("emitter did not return to idle after last digit");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && can_load) |=> last_reg == (state_reg == ST_IDLE))
        else $error("last flag disagrees with end of run");

endmodule

/* hdl/binary_to_decimal_ascii.sv */
// Top level of the 32-bit binary to decimal ASCII converter.
//
//  channel | signals                         | direction | transfer when
//  --------+---------------------------------+-----------+------------------------
//  in      | in_valid, in_stall, value       | input     | in_valid && !in_stall
//  out     | out_valid, out_stall,           | output    | out_valid && !out_stall
//          | digit_char, last                |           |
//
//  In the front end a value is loaded, goes through 32 shift-add-3 steps, then is queued.
//  The back end emits one digit per cycle while out_stall is low, 1 to 10 per value, overlapping the next conversion.
//  The front end takes no new value until the last one is queued; the one-bit-per-cycle loop limits throughput.
//  Reset clears the state machines and empties the two-entry queue; no clearing pass.
//  A stalled output holds its digit; the queue and front end stall behind it.
module binary_to_decimal_ascii
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bda_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bda_pkg::CHAR_W-1:0]    digit_char,
    output logic                          last
);

    bda_pkg::q_wr_t q_wr;
    bda_pkg::q_rd_t q_rd;
    logic           q_full;
    logic           pop;

    bda_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value    (value),
        .q_full   (q_full),
        .q_wr     (q_wr)
    );

    bda_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .pop    (pop),
        .q_rd   (q_rd)
    );

    bda_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_rd       (q_rd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit_char (digit_char),
        .last       (last)
    );

endmodule
